// ===== sv/delta_modulation_sample_player_unit_macros.svh =====
// assertion helpers for the checker
`ifndef DELTA_MODULATION_SAMPLE_PLAYER_UNIT_MACROS_SVH
`define DELTA_MODULATION_SAMPLE_PLAYER_UNIT_MACROS_SVH

// checked only while out of reset
`define DMSP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define DMSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/dmsp_pkg.sv =====
package dmsp_pkg;

  typedef enum logic [1:0] {
    FUNC_TICK     = 2'd0,
    FUNC_LOAD     = 2'd1,
    FUNC_NOTE_ON  = 2'd2,
    FUNC_NOTE_OFF = 2'd3
  } func_t;

  localparam int LEVEL_W = 7;
  localparam int PHASE_W = 27;
  localparam int SUM_W   = PHASE_W + 1;

  typedef struct packed {
    func_t       func;
    logic [7:0]  data_byte;
    logic        load_first;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               playing;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FETCH,
    S_EMIT
  } state_t;

  localparam logic [LEVEL_W-1:0] LEVEL_START = 7'd64;
  localparam logic [LEVEL_W-1:0] LEVEL_TOP   = 7'd125;
  localparam logic [LEVEL_W-1:0] LEVEL_STEP  = 7'd2;
  localparam logic [3:0]         BYTE_BITS   = 4'd8;

  localparam int               CFG_ADDR_W         = 3;
  localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_PHASE_INC = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_LOOP_EN   = 3'd4;

endpackage

// ===== sv/dmsp_stream_if.sv =====
interface dmsp_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/delta_modulation_sample_player_unit.sv =====
// One-bit delta-modulation sample player. Loads, note-on and note-off are accepted,
// then pass the emit state, which puts the result into the output register. A tick
// while playing steps through each whole phase unit crossed, one sample bit per cycle
// through a single level-step unit except where a new byte must first be fetched;
// each fetch passes the fetch state for the registered read of the sample memory.
// The block takes no new item while a tick is being worked off, but it does take one
// while the previous result still waits at the output. Sample memory has no reset;
// only bytes below the loaded length are ever read.
module delta_modulation_sample_player_unit
  import dmsp_pkg::*;
#(
  parameter int SAMPLE_DEPTH        = 4096,
  parameter int PHASE_FRACTION_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  dmsp_stream_if.sink           in_ch,
  dmsp_stream_if.source         out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int AW    = $clog2(SAMPLE_DEPTH);
  localparam int LEN_W = $clog2(SAMPLE_DEPTH + 1);
  localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(SAMPLE_DEPTH);
  localparam bit HAS_WRAP = PHASE_FRACTION_BITS < SUM_W;
  localparam logic [SUM_W-1:0] ONE =
    HAS_WRAP ? SUM_W'(64'd1 << PHASE_FRACTION_BITS) : '0;

  state_t state_r, state_nxt;

  logic [PHASE_W-1:0] inc_r;
  logic               loop_r;

  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [LEN_W-1:0]   pos_r, pos_nxt;
  logic [7:0]         shift_r, shift_nxt;
  logic [3:0]         bits_r, bits_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic               active_r, active_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r;
  logic               out_load;

  logic [7:0]         mem [SAMPLE_DEPTH];
  logic [7:0]         rd_data_r;
  logic               mem_we, rd_en;
  logic [AW-1:0]      wr_addr, rd_addr;

  logic               in_fire, cfg_we, wrap;
  logic [SUM_W-1:0]   sum_less;
  logic               step_bit;
  logic [7:0]         step_byte;
  logic [LEVEL_W-1:0] level_stepped;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_r  <= '0;
      loop_r <= 1'b0;
    end else if (cfg_we) begin
      case (paddr)
        CFG_ADDR_PHASE_INC: inc_r  <= pwdata[PHASE_W-1:0];
        CFG_ADDR_LOOP_EN:   loop_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      CFG_ADDR_PHASE_INC: prdata = {{(32-PHASE_W){1'b0}}, inc_r};
      CFG_ADDR_LOOP_EN:   prdata = {31'b0, loop_r};
      default:            prdata = '0;
    endcase
  end

  // handshakes
  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // shared bit-step unit: one phase unit and one sample bit per cycle, except while a byte read is issued
  assign wrap      = HAS_WRAP && (sum_r >= ONE);
  assign sum_less  = sum_r - ONE;
  assign step_byte = (state_r == S_FETCH) ? rd_data_r : shift_r;
  assign step_bit  = step_byte[0];

  always_comb begin
    if (step_bit) begin
      level_stepped = (level_r <= LEVEL_TOP) ? level_r + LEVEL_STEP : level_r;
    end else begin
      level_stepped = (level_r >= LEVEL_STEP) ? level_r - LEVEL_STEP : level_r;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    len_nxt    = len_r;
    pos_nxt    = pos_r;
    shift_nxt  = shift_r;
    bits_nxt   = bits_r;
    level_nxt  = level_r;
    active_nxt = active_r;
    phase_nxt  = phase_r;
    sum_nxt    = sum_r;
    mem_we     = 1'b0;
    wr_addr    = '0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    out_load   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EMIT;
          case (in_ch.data.func)
            FUNC_TICK: begin
              if (active_r && (len_r != '0)) begin
                sum_nxt   = {1'b0, phase_r} + {1'b0, inc_r};
                state_nxt = S_RUN;
              end
            end
            FUNC_LOAD: begin
              if (in_ch.data.load_first) begin
                mem_we  = 1'b1;
                wr_addr = '0;
                len_nxt = LEN_W'(1);
              end else if (len_r < DEPTH_LEN) begin
                mem_we  = 1'b1;
                wr_addr = len_r[AW-1:0];
                len_nxt = len_r + LEN_W'(1);
              end
            end
            FUNC_NOTE_ON: begin
              if (len_r != '0) begin
                pos_nxt    = '0;
                bits_nxt   = '0;
                level_nxt  = LEVEL_START;
                active_nxt = 1'b1;
              end
            end
            FUNC_NOTE_OFF: active_nxt = 1'b0;
            default: ;
          endcase
        end
      end

      S_RUN: begin
        if (wrap) begin
          if (bits_r != '0) begin
            level_nxt = level_stepped;
            shift_nxt = step_byte >> 1;
            bits_nxt  = bits_r - 4'd1;
            sum_nxt   = sum_less;
          end else if (pos_r < len_r) begin
            rd_en     = 1'b1;
            rd_addr   = pos_r[AW-1:0];
            pos_nxt   = pos_r + LEN_W'(1);
            state_nxt = S_FETCH;
          end else if (loop_r) begin
            rd_en     = 1'b1;
            rd_addr   = '0;
            pos_nxt   = LEN_W'(1);
            state_nxt = S_FETCH;
          end else begin
            // end of data: the unit just crossed is spent, the rest stays
            active_nxt = 1'b0;
            phase_nxt  = sum_less[PHASE_W-1:0];
            state_nxt  = S_EMIT;
          end
        end else begin
          phase_nxt = sum_r[PHASE_W-1:0];
          state_nxt = S_EMIT;
        end
      end

      S_FETCH: begin
        level_nxt = level_stepped;
        shift_nxt = step_byte >> 1;
        bits_nxt  = BYTE_BITS - 4'd1;
        sum_nxt   = sum_less;
        state_nxt = S_RUN;
      end

      S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      pos_r       <= '0;
      shift_r     <= '0;
      bits_r      <= '0;
      level_r     <= LEVEL_START;
      active_r    <= 1'b0;
      phase_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      pos_r       <= pos_nxt;
      shift_r     <= shift_nxt;
      bits_r      <= bits_nxt;
      level_r     <= level_nxt;
      active_r    <= active_nxt;
      phase_r     <= phase_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.level   <= level_r;
      out_data_r.playing <= active_r;
    end
  end

  // sample memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= in_ch.data.data_byte;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/dmsp_checker.sv =====
`include "delta_modulation_sample_player_unit_macros.svh"

module dmsp_checker
  import dmsp_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [LEVEL_W-1:0] out_level
);

  // a stalled result beat stays offered
  `DMSP_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result beat dropped while stalled")

  // every item leaves the block busy right after it is taken
  `DMSP_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && in_ready |=> !in_ready, "input taken twice in a row")

  // level starts at 64 and moves in steps of two, so it is always even
  `DMSP_ASSERT(a_level_even, clk, rst_n, out_valid |-> !out_level[0], "odd output level")

  `DMSP_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind delta_modulation_sample_player_unit dmsp_checker u_dmsp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_level (out_ch.data.level)
);

// ===== test/tb_delta_modulation_sample_player_unit.sv =====
`timescale 1ns / 100ps

module tb_delta_modulation_sample_player_unit;
  import dmsp_pkg::*;

  localparam int DEPTH       = 4096;
  localparam int FRAC        = 24;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE      = 40;
  localparam logic [PHASE_W-1:0] INC_MAX = {PHASE_W{1'b1}};
  localparam logic [PHASE_W-1:0] INC_ONE = 27'(1 << FRAC);

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  dmsp_stream_if #(.payload_t(in_item_t))  cmd_if ();
  dmsp_stream_if #(.payload_t(out_item_t)) lvl_if ();

  delta_modulation_sample_player_unit u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (cmd_if),
    .out_ch  (lvl_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predicted player state
  logic [7:0]         pcm_mem [0:DEPTH-1];
  logic [12:0]        pcm_len    = '0;
  logic [12:0]        rd_ptr     = '0;
  logic [7:0]         shreg      = '0;
  logic [3:0]         bit_cnt    = '0;
  logic [LEVEL_W-1:0] dac_level  = LEVEL_START;
  logic               is_playing = 1'b0;
  logic [PHASE_W-1:0] phase      = '0;
  logic [PHASE_W-1:0] phase_inc_cfg = '0;
  logic               loop_cfg      = 1'b0;

  in_item_t  sample_cmd_q [$];
  out_item_t level_exp_q [$];
  out_item_t want;

  int        err_cnt   = 0;
  int        cycle_cnt = 0;
  int        burst_left = 1;
  int        gap_left   = 0;
  logic      in_took    = 1'b0;
  logic [15:0] rdy_pat  = 16'hFFFF;
  logic [5:0]  rdy_age  = '0;

  function automatic logic consume_bit();
    if (bit_cnt == 0) begin
      if (rd_ptr < pcm_len) begin
        shreg   = pcm_mem[rd_ptr[11:0]];
        rd_ptr  = rd_ptr + 13'd1;
        bit_cnt = BYTE_BITS;
      end else if (loop_cfg) begin
        shreg   = pcm_mem[0];
        rd_ptr  = 13'd1;
        bit_cnt = BYTE_BITS;
      end else begin
        is_playing = 1'b0;
        return 1'b0;
      end
    end
    if (shreg[0]) begin
      if (dac_level <= LEVEL_TOP) dac_level = dac_level + LEVEL_STEP;
    end else if (dac_level >= LEVEL_STEP) begin
      dac_level = dac_level - LEVEL_STEP;
    end
    shreg   = shreg >> 1;
    bit_cnt = bit_cnt - 4'd1;
    return 1'b1;
  endfunction

  function automatic void advance_phase();
    logic [PHASE_W:0] acc;
    logic [3:0]       wraps;
    if (!is_playing || pcm_len == 0) return;
    acc   = {1'b0, phase} + {1'b0, phase_inc_cfg};
    wraps = acc[PHASE_W:FRAC];
    while (wraps != 0) begin
      wraps = wraps - 4'd1;
      if (!consume_bit()) break;
    end
    // whole units left after a stop are kept above the fraction
    phase = {wraps[2:0], acc[FRAC-1:0]};
  endfunction

  function automatic out_item_t predict_level(in_item_t it);
    out_item_t r;
    case (it.func)
      FUNC_TICK: advance_phase();
      FUNC_LOAD: begin
        if (it.load_first) pcm_len = '0;
        if (pcm_len < DEPTH) begin
          pcm_mem[pcm_len[11:0]] = it.data_byte;
          pcm_len = pcm_len + 13'd1;
        end
      end
      FUNC_NOTE_ON: begin
        if (pcm_len != 0) begin
          rd_ptr     = '0;
          bit_cnt    = '0;
          dac_level  = LEVEL_START;
          is_playing = 1'b1;
        end
      end
      default: is_playing = 1'b0;
    endcase
    r.level   = dac_level;
    r.playing = is_playing;
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // command driver: bursts with random gaps, valid held until taken
  always @(negedge clk) begin
    if (in_took) void'(sample_cmd_q.pop_front());
    if (!rst_n) begin
      cmd_if.valid <= 1'b0;
    end else if (!(cmd_if.valid && !in_took)) begin
      if (gap_left > 0) begin
        cmd_if.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (sample_cmd_q.size() != 0) begin
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= sample_cmd_q[0];
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 32);
          gap_left   <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
  end

  // level receiver: rotating stall pattern, reloaded whenever the age counter wraps
  always @(negedge clk) begin
    if (!rst_n) lvl_if.ready <= 1'b0;
    else lvl_if.ready <= rdy_pat[0];
    rdy_age <= rdy_age + 6'd1;
    if (rdy_age == 6'd63)
      rdy_pat <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
    else
      rdy_pat <= {rdy_pat[0], rdy_pat[15:1]};
  end

  always @(posedge clk) begin
    in_took <= rst_n && cmd_if.valid && cmd_if.ready;
    if (rst_n && lvl_if.valid && lvl_if.ready) begin
      if (level_exp_q.size() == 0) begin
        $display("%0t: unexpected beat, level %0d playing %0d", $time,
                 lvl_if.data.level, lvl_if.data.playing);
        err_cnt++;
      end else begin
        want = level_exp_q.pop_front();
        if (lvl_if.data.level !== want.level) begin
          $display("%0t: level expected %0d actual %0d", $time, want.level,
                   lvl_if.data.level);
          err_cnt++;
        end
        if (lvl_if.data.playing !== want.playing) begin
          $display("%0t: playing expected %0d actual %0d", $time, want.playing,
                   lvl_if.data.playing);
          err_cnt++;
        end
      end
    end
    if (rst_n && cmd_if.valid && cmd_if.ready)
      level_exp_q.push_back(predict_level(cmd_if.data));
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("delta_modulation_sample_player_unit verification failed");
    $finish;
  end

  task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_player_cfg(input logic [PHASE_W-1:0] inc, input logic loop_en);
    apb_write(CFG_ADDR_PHASE_INC, {5'd0, inc});
    apb_write(CFG_ADDR_LOOP_EN, {31'd0, loop_en});
    phase_inc_cfg = inc;
    loop_cfg      = loop_en;
  endtask

  task automatic push_cmd(input func_t f, input logic [7:0] b, input logic first);
    in_item_t it;
    it.func       = f;
    it.data_byte  = b;
    it.load_first = first;
    sample_cmd_q.push_back(it);
  endtask

  // sender holds off until every expected beat is back, then lets the block settle
  task automatic wait_drained();
    @(posedge clk);
    while (sample_cmd_q.size() != 0 || level_exp_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic add_random_traffic(input int n_items);
    int n;
    int nb;
    int nt;
    int k;
    n = 0;
    while (n < n_items) begin
      if ($urandom_range(0, 9) < 7) begin
        nb = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (int i = 0; i < nb; i++) push_cmd(FUNC_LOAD, 8'($urandom), i == 0);
        push_cmd(FUNC_NOTE_ON, 8'($urandom), 1'($urandom));
        nt = $urandom_range(1, 30);
        for (int i = 0; i < nt; i++) push_cmd(FUNC_TICK, 8'($urandom), 1'($urandom));
        n += nb + nt + 1;
        if ($urandom_range(0, 3) == 0) begin
          // reload, often shorter, while still playing
          k = $urandom_range(1, 4);
          for (int i = 0; i < k; i++) push_cmd(FUNC_LOAD, 8'($urandom), i == 0);
          nt = $urandom_range(1, 20);
          for (int i = 0; i < nt; i++) push_cmd(FUNC_TICK, 8'($urandom), 1'($urandom));
          n += k + nt;
        end
        if ($urandom_range(0, 2) == 0) begin
          push_cmd(FUNC_NOTE_OFF, 8'($urandom), 1'($urandom));
          n++;
        end
      end else begin
        k = $urandom_range(1, 6);
        for (int i = 0; i < k; i++)
          push_cmd(func_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
        n += k;
      end
    end
  endtask

  initial begin
    logic [PHASE_W-1:0] inc;
    rst_n        = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    cmd_if.valid = 1'b0;
    cmd_if.data  = '0;
    lvl_if.ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (SETTLE) @(posedge clk);

    // directed: idle tick, note-on with nothing loaded, ceiling and floor, running out
    set_player_cfg(INC_MAX, 1'b0);
    push_cmd(FUNC_TICK, 8'h00, 1'b0);
    push_cmd(FUNC_NOTE_ON, 8'hFF, 1'b1);
    push_cmd(FUNC_NOTE_OFF, 8'h00, 1'b0);
    push_cmd(FUNC_LOAD, 8'hFF, 1'b1);
    repeat (4) push_cmd(FUNC_LOAD, 8'hFF, 1'b0);
    push_cmd(FUNC_NOTE_ON, 8'h00, 1'b0);
    repeat (6) push_cmd(FUNC_TICK, 8'hFF, 1'b1);
    push_cmd(FUNC_TICK, 8'h00, 1'b0);
    push_cmd(FUNC_LOAD, 8'h00, 1'b1);
    repeat (4) push_cmd(FUNC_LOAD, 8'h00, 1'b0);
    push_cmd(FUNC_NOTE_ON, 8'hFF, 1'b0);
    repeat (6) push_cmd(FUNC_TICK, 8'h00, 1'b0);
    push_cmd(FUNC_NOTE_OFF, 8'hFF, 1'b1);
    push_cmd(FUNC_TICK, 8'h00, 1'b0);
    wait_drained();

    // looping, then a shorter reload while playing
    set_player_cfg(INC_ONE, 1'b1);
    push_cmd(FUNC_LOAD, 8'h3C, 1'b1);
    push_cmd(FUNC_LOAD, 8'hC3, 1'b0);
    push_cmd(FUNC_NOTE_ON, 8'h00, 1'b0);
    repeat (20) push_cmd(FUNC_TICK, 8'h00, 1'b0);
    push_cmd(FUNC_LOAD, 8'h01, 1'b1);
    repeat (10) push_cmd(FUNC_TICK, 8'h00, 1'b0);
    push_cmd(FUNC_NOTE_OFF, 8'h00, 1'b0);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_player_cfg('0, 1'b0);
        1: set_player_cfg(INC_MAX, 1'b1);
        2: set_player_cfg(INC_ONE, 1'($urandom));
        default: begin
          case ($urandom_range(0, 3))
            0: inc = 27'($urandom_range(1, (1 << FRAC) - 1));
            1: inc = 27'($urandom_range(1 << FRAC, 1 << 26));
            2: inc = 27'($urandom);
            default: inc = 27'($urandom_range(0, 255));
          endcase
          set_player_cfg(inc, 1'($urandom));
        end
      endcase
      add_random_traffic(180);
      wait_drained();
    end

    if (err_cnt == 0) begin
      $display("delta_modulation_sample_player_unit verification clean");
    end else begin
      $display("delta_modulation_sample_player_unit verification failed");
    end
    $finish;
  end

endmodule
